@@ rtl/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg
// types and constants shared by the sorted score table and its cells
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int unsigned ScoreW = 32;
  localparam int unsigned NumberW = 32;
  localparam int unsigned WordW = 64;
  localparam int unsigned FieldIdxW = 5;
  localparam int unsigned OpW = 2;
  localparam int unsigned StatusW = 2;

  typedef enum logic [OpW-1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_READ     = 2'd2,
    OP_TRUNCATE = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [ScoreW-1:0]  score;
    logic signed [NumberW-1:0] number;
    logic [WordW-1:0]          name_word;
    logic [WordW-1:0]          extra_word;
  } entry_t;

  typedef struct packed {
    logic en;
    op_e  op;
    logic slot_valid;
    logic at_count;
    logic at_or_after_idx;
  } cell_ctrl_t;

endpackage

@@ rtl/sst_if.sv @@
// ----------------------------------------------------------------------------
// sst channel interfaces
// valid/ready channels for commands into and responses out of the table
// ----------------------------------------------------------------------------
interface sst_cmd_if;
  logic                                    valid;
  logic                                    ready;
  logic [sst_pkg::OpW-1:0]                 opcode;
  logic signed [sst_pkg::ScoreW-1:0]       score;
  logic signed [sst_pkg::NumberW-1:0]      number;
  logic [sst_pkg::WordW-1:0]               name_word;
  logic [sst_pkg::WordW-1:0]               extra_word;
  logic [sst_pkg::FieldIdxW-1:0]           index;

  modport source (
    output valid, opcode, score, number, name_word, extra_word, index,
    input  ready
  );
  modport sink (
    input  valid, opcode, score, number, name_word, extra_word, index,
    output ready
  );
endinterface

interface sst_rsp_if;
  logic                                    valid;
  logic                                    ready;
  logic [sst_pkg::StatusW-1:0]             status;
  logic [sst_pkg::FieldIdxW-1:0]           position;
  logic                                    found;
  logic signed [sst_pkg::ScoreW-1:0]       read_score;
  logic signed [sst_pkg::NumberW-1:0]      read_number;
  logic [sst_pkg::WordW-1:0]               read_name;
  logic [sst_pkg::WordW-1:0]               read_extra;
  logic [sst_pkg::FieldIdxW-1:0]           entry_total;

  modport source (
    output valid, status, position, found, read_score, read_number, read_name,
           read_extra, entry_total,
    input  ready
  );
  modport sink (
    input  valid, status, position, found, read_score, read_number, read_name,
           read_extra, entry_total,
    output ready
  );
endinterface

@@ rtl/sst_cell.sv @@
// ----------------------------------------------------------------------------
// sst_cell
// one table slot: compares its score with the new entry and takes the new
// entry or a neighbor's entry on insert and remove
// ----------------------------------------------------------------------------
module sst_cell (
  input  logic                clk_i,
  input  sst_pkg::cell_ctrl_t ctrl_i,
  input  sst_pkg::entry_t     new_entry_i,
  input  sst_pkg::entry_t     left_entry_i,
  input  sst_pkg::entry_t     right_entry_i,
  input  logic                left_ins_i,
  output logic                ins_o,
  output sst_pkg::entry_t     entry_o
);

  sst_pkg::entry_t entry_q, entry_d;

  // new entry lands at or before this slot
  assign ins_o = ctrl_i.slot_valid && (entry_q.score <= new_entry_i.score);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.en) begin
      unique case (ctrl_i.op)
        sst_pkg::OP_INSERT: begin
          if (left_ins_i) begin
            entry_d = left_entry_i;
          end else if (ins_o || ctrl_i.at_count) begin
            entry_d = new_entry_i;
          end
        end
        sst_pkg::OP_REMOVE: begin
          if (ctrl_i.at_or_after_idx) begin
            entry_d = right_entry_i;
          end
        end
        default: begin
          entry_d = entry_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

@@ rtl/sorted_score_table.sv @@
// ----------------------------------------------------------------------------
// sorted_score_table
// table of up to DEPTH entries held in descending score order in a row of
// cells; insert, remove, read and truncate
// ----------------------------------------------------------------------------
// response: registered, valid in the cycle after the command transaction
// throughput: one command per cycle while responses are taken; the cells shift
// in parallel and the response register frees as soon as the response is taken
// reset: entry count and response valid clear; slot contents are left as is
// ----------------------------------------------------------------------------
module sorted_score_table #(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sst_cmd_if.sink   cmd_i,
  sst_rsp_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > sst_pkg::FieldIdxW) ? CntW : sst_pkg::FieldIdxW;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            rsp_valid_q;
  logic [sst_pkg::StatusW-1:0]        status_q, status_d;
  logic [sst_pkg::FieldIdxW-1:0]      position_q, position_d;
  logic                               found_q, found_d;
  sst_pkg::entry_t                    rd_q, rd_d;
  logic [sst_pkg::FieldIdxW-1:0]      total_q;

  logic            fire;
  sst_pkg::op_e    op;
  sst_pkg::entry_t new_entry;
  logic [CmpW-1:0] idx_ext, cnt_ext;

  sst_pkg::entry_t   cell_entry [DEPTH];
  logic [DEPTH-1:0]  cell_ins;
  sst_pkg::cell_ctrl_t cell_ctrl [DEPTH];

  logic [CntW-1:0] ins_pos;
  logic            ins_hit;
  sst_pkg::entry_t sel_entry;

  assign cmd_i.ready = !rsp_valid_q || rsp_o.ready;
  assign fire        = cmd_i.valid && cmd_i.ready;
  assign op          = sst_pkg::op_e'(cmd_i.opcode);
  assign idx_ext     = CmpW'(cmd_i.index);
  assign cnt_ext     = CmpW'(cnt_q);

  assign new_entry.score      = cmd_i.score;
  assign new_entry.number     = cmd_i.number;
  assign new_entry.name_word  = cmd_i.name_word;
  assign new_entry.extra_word = cmd_i.extra_word;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    sst_pkg::entry_t left_entry, right_entry;
    logic            left_ins;

    assign cell_ctrl[g].en              = fire;
    assign cell_ctrl[g].op              = op;
    assign cell_ctrl[g].slot_valid      = CmpW'(g) < cnt_ext;
    assign cell_ctrl[g].at_count        = CmpW'(g) == cnt_ext;
    assign cell_ctrl[g].at_or_after_idx = CmpW'(g) >= idx_ext;

    if (g == 0) begin : g_first
      assign left_entry = new_entry;
      assign left_ins   = 1'b0;
    end else begin : g_mid
      assign left_entry = cell_entry[g-1];
      assign left_ins   = cell_ins[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_entry = cell_entry[g];
    end else begin : g_inner
      assign right_entry = cell_entry[g+1];
    end

    sst_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (cell_ctrl[g]),
      .new_entry_i   (new_entry),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .left_ins_i    (left_ins),
      .ins_o         (cell_ins[g]),
      .entry_o       (cell_entry[g])
    );
  end

  // first slot the new entry goes ahead of, else the end of the table
  always_comb begin
    ins_pos = cnt_q;
    ins_hit = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_ins[i] && !ins_hit) begin
        ins_pos = CntW'(i);
        ins_hit = 1'b1;
      end
    end
  end

  always_comb begin
    sel_entry = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (idx_ext == CmpW'(i)) begin
        sel_entry = cell_entry[i];
      end
    end
  end

  always_comb begin
    cnt_d      = cnt_q;
    status_d   = sst_pkg::ST_OK;
    position_d = '0;
    found_d    = 1'b0;
    rd_d       = '0;
    unique case (op)
      sst_pkg::OP_INSERT: begin
        if ((cnt_ext == CmpW'(DEPTH)) && !ins_hit) begin
          status_d = sst_pkg::ST_FULL;
        end else begin
          position_d = sst_pkg::FieldIdxW'(ins_pos);
          if (cnt_ext < CmpW'(DEPTH)) begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      sst_pkg::OP_REMOVE: begin
        if (idx_ext >= cnt_ext) begin
          status_d = sst_pkg::ST_BAD_INDEX;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      sst_pkg::OP_READ: begin
        if (idx_ext < cnt_ext) begin
          found_d = 1'b1;
          rd_d    = sel_entry;
        end else begin
          rd_d.score  = '1;
          rd_d.number = '1;
        end
      end
      sst_pkg::OP_TRUNCATE: begin
        if (cnt_ext > idx_ext) begin
          cnt_d = CntW'(idx_ext);
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        cnt_q <= cnt_d;
      end
      if (fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q   <= status_d;
      position_q <= position_d;
      found_q    <= found_d;
      rd_q       <= rd_d;
      total_q    <= sst_pkg::FieldIdxW'(cnt_d);
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.position    = position_q;
  assign rsp_o.found       = found_q;
  assign rsp_o.read_score  = rd_q.score;
  assign rsp_o.read_number = rd_q.number;
  assign rsp_o.read_name   = rd_q.name_word;
  assign rsp_o.read_extra  = rd_q.extra_word;
  assign rsp_o.entry_total = total_q;

endmodule

@@ tb/tb_sorted_score_table.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_score_table
// directed and random insert, remove, read and truncate commands under idle
// and stall patterns, each response checked against a behavioral table
// ----------------------------------------------------------------------------
module tb_sorted_score_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 16;
  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    sst_pkg::op_e                       op;
    logic signed [sst_pkg::ScoreW-1:0]  score;
    logic signed [sst_pkg::NumberW-1:0] number;
    logic [sst_pkg::WordW-1:0]          name_word;
    logic [sst_pkg::WordW-1:0]          extra_word;
    logic [sst_pkg::FieldIdxW-1:0]      index;
  } score_cmd_t;

  typedef struct packed {
    sst_pkg::status_e                   status;
    logic [sst_pkg::FieldIdxW-1:0]      position;
    logic                               found;
    logic signed [sst_pkg::ScoreW-1:0]  read_score;
    logic signed [sst_pkg::NumberW-1:0] read_number;
    logic [sst_pkg::WordW-1:0]          read_name;
    logic [sst_pkg::WordW-1:0]          read_extra;
    logic [sst_pkg::FieldIdxW-1:0]      entry_total;
  } score_rsp_t;

  logic clk;
  logic rst_n;

  sst_cmd_if cmd_if ();
  sst_rsp_if rsp_if ();

  sorted_score_table #(
    .DEPTH(Depth)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  sst_pkg::entry_t ranked_entries [Depth];
  int unsigned     held_total;
  score_rsp_t      pending_rsp_q [$];
  int unsigned     err_count;
  int unsigned     cycle_count;
  int unsigned     src_idle_pct;
  int unsigned     snk_stall_pct;
  bit              hold_off;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want_v);
    err_count++;
    $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want_v);
  endtask

  // behavioral table: updates the held entries and returns the response
  function automatic score_rsp_t apply_table_op(score_cmd_t c);
    score_rsp_t  r;
    int unsigned pos;
    int unsigned last;
    int unsigned i;
    r = '0;
    r.status = sst_pkg::ST_OK;
    case (c.op)
      sst_pkg::OP_INSERT: begin
        pos = held_total;
        for (i = 0; i < held_total; i++) begin
          if (ranked_entries[i].score <= c.score) begin
            pos = i;
            break;
          end
        end
        if (held_total >= Depth && pos >= Depth) begin
          r.status = sst_pkg::ST_FULL;
        end else begin
          last = (held_total < Depth) ? held_total : Depth - 1;
          for (i = last; i > pos; i--) ranked_entries[i] = ranked_entries[i-1];
          ranked_entries[pos].score = c.score;
          ranked_entries[pos].number = c.number;
          ranked_entries[pos].name_word = c.name_word;
          ranked_entries[pos].extra_word = c.extra_word;
          if (held_total < Depth) held_total++;
          r.position = pos[sst_pkg::FieldIdxW-1:0];
        end
      end
      sst_pkg::OP_REMOVE: begin
        if (32'(c.index) >= held_total) begin
          r.status = sst_pkg::ST_BAD_INDEX;
        end else begin
          for (i = 32'(c.index); i + 1 < held_total; i++)
            ranked_entries[i] = ranked_entries[i+1];
          held_total--;
        end
      end
      sst_pkg::OP_READ: begin
        if (32'(c.index) < held_total) begin
          r.found = 1'b1;
          r.read_score = ranked_entries[c.index].score;
          r.read_number = ranked_entries[c.index].number;
          r.read_name = ranked_entries[c.index].name_word;
          r.read_extra = ranked_entries[c.index].extra_word;
        end else begin
          r.read_score = -1;
          r.read_number = -1;
        end
      end
      default: begin
        if (held_total > 32'(c.index)) held_total = 32'(c.index);
      end
    endcase
    r.entry_total = held_total[sst_pkg::FieldIdxW-1:0];
    return r;
  endfunction

  function automatic score_cmd_t make_cmd(sst_pkg::op_e op,
                                          logic signed [sst_pkg::ScoreW-1:0] sc,
                                          logic signed [sst_pkg::NumberW-1:0] nu,
                                          logic [sst_pkg::WordW-1:0] nw,
                                          logic [sst_pkg::WordW-1:0] ew,
                                          logic [sst_pkg::FieldIdxW-1:0] idx);
    score_cmd_t c;
    c.op = op;
    c.score = sc;
    c.number = nu;
    c.name_word = nw;
    c.extra_word = ew;
    c.index = idx;
    return c;
  endfunction

  function automatic score_cmd_t random_cmd();
    score_cmd_t  c;
    int unsigned r;
    c.score = $urandom;
    c.number = $urandom;
    c.name_word = {$urandom, $urandom};
    c.extra_word = {$urandom, $urandom};
    c.index = sst_pkg::FieldIdxW'($urandom_range(0, Depth));
    case ($urandom_range(9))
      0, 1: c.score = $signed($urandom_range(6)) - 3;
      2: begin
        case ($urandom_range(3))
          0: c.score = 32'sh7fff_ffff;
          1: c.score = 32'sh8000_0000;
          2: c.score = 0;
          default: c.score = -1;
        endcase
      end
      3: if (held_total > 0) c.score = ranked_entries[$urandom_range(held_total - 1)].score;
      default: ;
    endcase
    r = $urandom_range(99);
    if (r < ((held_total < Depth) ? 50 : 35)) begin
      c.op = sst_pkg::OP_INSERT;
    end else if (r < 70) begin
      c.op = sst_pkg::OP_REMOVE;
    end else if (r < 74) begin
      c.op = sst_pkg::OP_TRUNCATE;
      if ($urandom_range(1) == 0)
        c.index = sst_pkg::FieldIdxW'(
          $urandom_range((held_total > 0) ? held_total - 1 : 0, Depth));
    end else begin
      c.op = sst_pkg::OP_READ;
    end
    if ((c.op == sst_pkg::OP_REMOVE || c.op == sst_pkg::OP_READ) && $urandom_range(9) < 8)
      c.index = sst_pkg::FieldIdxW'($urandom_range(0, held_total));
    return c;
  endfunction

  // entered and left at a falling edge; valid stays high between back-to-back commands
  task automatic send_cmd(score_cmd_t c);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      cmd_if.valid = 1'b0;
      @(negedge clk);
    end
    cmd_if.opcode = c.op;
    cmd_if.score = c.score;
    cmd_if.number = c.number;
    cmd_if.name_word = c.name_word;
    cmd_if.extra_word = c.extra_word;
    cmd_if.index = c.index;
    cmd_if.valid = 1'b1;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
    pending_rsp_q.push_back(apply_table_op(c));
    @(negedge clk);
  endtask

  task automatic test_empty_table();
    send_cmd(make_cmd(sst_pkg::OP_READ, 0, 0, '0, '0, 0));
    send_cmd(make_cmd(sst_pkg::OP_REMOVE, 0, 0, '0, '0, 0));
    send_cmd(make_cmd(sst_pkg::OP_TRUNCATE, 0, 0, '0, '0, 0));
    send_cmd(make_cmd(sst_pkg::OP_READ, 0, 0, '0, '0, sst_pkg::FieldIdxW'(Depth)));
  endtask

  task automatic test_insert_order();
    send_cmd(make_cmd(sst_pkg::OP_INSERT, 32'sh7fff_ffff, 32'sh7fff_ffff, '1, '1, 5'h1f));
    send_cmd(make_cmd(sst_pkg::OP_INSERT, 32'sh8000_0000, 32'sh8000_0000, '0, '0, 0));
    send_cmd(make_cmd(sst_pkg::OP_INSERT, 0, 5, 64'h0123_4567_89ab_cdef,
                      64'hfedc_ba98_7654_3210, 0));
    // equal score goes ahead of the older one
    send_cmd(make_cmd(sst_pkg::OP_INSERT, 0, 6, 64'h5555_aaaa_5555_aaaa,
                      64'haaaa_5555_aaaa_5555, 0));
    send_cmd(make_cmd(sst_pkg::OP_READ, 0, 0, '0, '0, 1));
    send_cmd(make_cmd(sst_pkg::OP_READ, 0, 0, '0, '0, 2));
    send_cmd(make_cmd(sst_pkg::OP_READ, 0, 0, '0, '0, 4));
    send_cmd(make_cmd(sst_pkg::OP_REMOVE, 0, 0, '0, '0, 4));
    send_cmd(make_cmd(sst_pkg::OP_REMOVE, 0, 0, '0, '0, 0));
    send_cmd(make_cmd(sst_pkg::OP_TRUNCATE, 0, 0, '0, '0, sst_pkg::FieldIdxW'(Depth)));
    send_cmd(make_cmd(sst_pkg::OP_TRUNCATE, 0, 0, '0, '0, 1));
    send_cmd(make_cmd(sst_pkg::OP_READ, 0, 0, '0, '0, 0));
  endtask

  task automatic test_full_table();
    send_cmd(make_cmd(sst_pkg::OP_TRUNCATE, 0, 0, '0, '0, 0));
    for (int k = 0; k < Depth; k++)
      send_cmd(make_cmd(sst_pkg::OP_INSERT, 1000 - 50 * k, k, {$urandom, $urandom},
                        {$urandom, $urandom}, 0));
    // ranks last: refused
    send_cmd(make_cmd(sst_pkg::OP_INSERT, -5, 99, '1, '1, 0));
    // ties the lowest: replaces it
    send_cmd(make_cmd(sst_pkg::OP_INSERT, 250, 98, '1, '0, 0));
    send_cmd(make_cmd(sst_pkg::OP_INSERT, 10000, 97, '0, '1, 0));
    send_cmd(make_cmd(sst_pkg::OP_READ, 0, 0, '0, '0, sst_pkg::FieldIdxW'(Depth - 1)));
    send_cmd(make_cmd(sst_pkg::OP_READ, 0, 0, '0, '0, sst_pkg::FieldIdxW'(Depth)));
    send_cmd(make_cmd(sst_pkg::OP_REMOVE, 0, 0, '0, '0, sst_pkg::FieldIdxW'(Depth - 1)));
    send_cmd(make_cmd(sst_pkg::OP_TRUNCATE, 0, 0, '0, '0, 0));
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    fork
      begin
        @(posedge clk);
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    repeat (40) send_cmd(random_cmd());
  endtask

  task automatic test_random_mix();
    int unsigned idle_set [4] = '{0, 74, 0, 33};
    int unsigned stall_set [4] = '{0, 0, 74, 33};
    for (int p = 0; p < 4; p++) begin
      src_idle_pct = idle_set[p];
      snk_stall_pct = stall_set[p];
      repeat (245) send_cmd(random_cmd());
    end
  endtask

  // response sink
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_if.ready = !hold_off && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // response checker
  initial begin
    score_rsp_t want;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready) begin
        if (pending_rsp_q.size() == 0) begin
          report_mismatch("unexpected transaction", 64'(rsp_if.status), 64'd0);
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp_if.status !== want.status)
            report_mismatch("status", 64'(rsp_if.status), 64'(want.status));
          if (rsp_if.position !== want.position)
            report_mismatch("position", 64'(rsp_if.position), 64'(want.position));
          if (rsp_if.found !== want.found)
            report_mismatch("found", 64'(rsp_if.found), 64'(want.found));
          if (rsp_if.read_score !== want.read_score)
            report_mismatch("read_score", 64'(rsp_if.read_score), 64'(want.read_score));
          if (rsp_if.read_number !== want.read_number)
            report_mismatch("read_number", 64'(rsp_if.read_number), 64'(want.read_number));
          if (rsp_if.read_name !== want.read_name)
            report_mismatch("read_name", rsp_if.read_name, want.read_name);
          if (rsp_if.read_extra !== want.read_extra)
            report_mismatch("read_extra", rsp_if.read_extra, want.read_extra);
          if (rsp_if.entry_total !== want.entry_total)
            report_mismatch("entry_total", 64'(rsp_if.entry_total), 64'(want.entry_total));
        end
      end
    end
  end

  initial begin
    err_count = 0;
    held_total = 0;
    hold_off = 1'b0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    cmd_if.valid = 1'b0;
    cmd_if.opcode = sst_pkg::OP_INSERT;
    cmd_if.score = '0;
    cmd_if.number = '0;
    cmd_if.name_word = '0;
    cmd_if.extra_word = '0;
    cmd_if.index = '0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_empty_table();
    test_insert_order();
    test_full_table();
    test_backpressure();
    test_random_mix();
    cmd_if.valid = 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sst_pkg.sv
rtl/sst_if.sv
rtl/sst_cell.sv
rtl/sorted_score_table.sv
tb/tb_sorted_score_table.sv
